// File: design/ilst_pkg.sv
// ----------------------------------------------------------------------------
// ilst_pkg
// Shared types and constants for the indexed list store: list capacity,
// operation and status codes, beat structs and the per-cell control bundle.
// ----------------------------------------------------------------------------
package ilst_pkg;

	localparam int DEPTH  = 256;
	localparam int WORD_W = 32;
	localparam int LEN_W  = 9;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	// index width covers both the count and the 9-bit position field
	localparam int IDX_W  = (CNT_W > LEN_W) ? CNT_W : LEN_W;
	localparam int GRP    = 16;
	localparam int NGRP   = (DEPTH + GRP - 1) / GRP;

	localparam logic [IDX_W-1:0] DEPTH_I = IDX_W'(DEPTH);

	localparam logic [2:0] OP_PUSH   = 3'd0;
	localparam logic [2:0] OP_POP    = 3'd1;
	localparam logic [2:0] OP_INSERT = 3'd2;
	localparam logic [2:0] OP_ERASE  = 3'd3;
	localparam logic [2:0] OP_READ   = 3'd4;
	localparam logic [2:0] OP_CLEAR  = 3'd5;
	localparam logic [2:0] OP_RESIZE = 3'd6;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	typedef struct packed {
		logic [2:0]               kind;
		logic [LEN_W-1:0]         position;
		logic signed [WORD_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] read_value;
		logic [LEN_W-1:0]         length;
		logic [1:0]               status;
	} rsp_t;

	typedef struct packed {
		logic              push;
		logic              insert;
		logic              erase;
		logic              resize;
		logic [IDX_W-1:0]  pos;
		logic [IDX_W-1:0]  count;
		logic [WORD_W-1:0] word;
	} cell_ctrl_t;

endpackage

// File: design/indexed_list_store_unit.sv
// ----------------------------------------------------------------------------
// indexed_list_store_unit
// Bounded ordered list of signed words built as a chain of cells. Push, pop,
// insert, erase, read, clear and resize each complete in one update of the
// chain; reads gather through a two-level registered OR tree.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | beat
//  req     | in        | req_valid / req_stall | req_t  (kind, position, value)
//  rsp     | out       | rsp_valid / rsp_stall | rsp_t  (read_value, length, status)
//
//  After acceptance the result is built in order: the EXEC state updates
//  the cells and registers the first OR level, the GATHER state puts the
//  second OR level into the result register; a new item is accepted once
//  the unit is back in IDLE. The cell chain shifts in one update in EXEC.
//  Reset clears the length and control; cell contents are undefined.
//  A stalled result holds in the output register; the next item is taken
//  meanwhile and waits in the gather step until the register frees.
// ----------------------------------------------------------------------------
module indexed_list_store_unit import ilst_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_EXEC   = 3'b010,
		S_GATHER = 3'b100
	} state_t;

	state_t             state_q;
	req_t               op_q;
	logic [CNT_W-1:0]   count_q;
	logic [LEN_W-1:0]   len_s1;
	logic [1:0]         stat_s1;
	logic               rd_ok_s1;
	logic [WORD_W-1:0]  grp_s1 [NGRP];
	rsp_t               rsp_q;
	logic               rsp_valid_q;

	logic [IDX_W-1:0]   pos_x;
	logic [IDX_W-1:0]   cnt_x;
	logic [IDX_W-1:0]   cnt_d;
	logic [1:0]         stat_d;
	logic               ok_d;
	cell_ctrl_t         ctrl;
	logic [WORD_W-1:0]  words [DEPTH];
	logic [WORD_W-1:0]  taps  [DEPTH];
	logic [WORD_W-1:0]  grp_d [NGRP];
	logic [WORD_W-1:0]  gather;
	logic               accept;
	logic               rsp_free;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_free  = !rsp_valid_q || !rsp_stall;

	assign pos_x = IDX_W'(op_q.position);
	assign cnt_x = IDX_W'(count_q);

	// status and new length of the held operation
	always_comb begin
		stat_d = ST_OK;
		cnt_d  = cnt_x;
		case (op_q.kind)
			OP_PUSH: begin
				if (cnt_x >= DEPTH_I) stat_d = ST_FULL;
				else                  cnt_d  = cnt_x + IDX_W'(1);
			end
			OP_POP: begin
				if (cnt_x == '0) stat_d = ST_EMPTY;
				else             cnt_d  = cnt_x - IDX_W'(1);
			end
			OP_INSERT: begin
				if (cnt_x >= DEPTH_I)   stat_d = ST_FULL;
				else if (pos_x > cnt_x) stat_d = ST_RANGE;
				else                    cnt_d  = cnt_x + IDX_W'(1);
			end
			OP_ERASE: begin
				if (cnt_x == '0)         stat_d = ST_EMPTY;
				else if (pos_x >= cnt_x) stat_d = ST_RANGE;
				else                     cnt_d  = cnt_x - IDX_W'(1);
			end
			OP_READ: begin
				if (pos_x >= cnt_x) stat_d = ST_RANGE;
			end
			OP_CLEAR: begin
				cnt_d = '0;
			end
			OP_RESIZE: begin
				if (pos_x > DEPTH_I) stat_d = ST_FULL;
				else                 cnt_d  = pos_x;
			end
			default: begin
				stat_d = ST_OK;
			end
		endcase
	end

	assign ok_d = (state_q == S_EXEC) && (stat_d == ST_OK);

	always_comb begin
		ctrl.push   = ok_d && (op_q.kind == OP_PUSH);
		ctrl.insert = ok_d && (op_q.kind == OP_INSERT);
		ctrl.erase  = ok_d && (op_q.kind == OP_ERASE);
		ctrl.resize = ok_d && (op_q.kind == OP_RESIZE);
		ctrl.pos    = pos_x;
		ctrl.count  = cnt_x;
		ctrl.word   = op_q.value;
	end

	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		logic [WORD_W-1:0] left_w;
		logic [WORD_W-1:0] right_w;

		if (k == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = words[k-1];
		end
		if (k == DEPTH - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = words[k+1];
		end

		ilst_cell u_cell (
			.clk    (clk),
			.idx    (IDX_W'(k)),
			.ctrl   (ctrl),
			.left   (left_w),
			.right  (right_w),
			.word_q (words[k]),
			.tap    (taps[k])
		);
	end

	// first OR level: one group of taps each
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_d[g] = '0;
			for (int j = 0; j < GRP; j++) begin
				if (g * GRP + j < DEPTH) begin
					grp_d[g] = grp_d[g] | taps[g * GRP + j];
				end
			end
		end
	end

	always_comb begin
		gather = '0;
		for (int g = 0; g < NGRP; g++) begin
			gather = gather | grp_s1[g];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EXEC) begin
			grp_s1   <= grp_d;
			len_s1   <= cnt_d[LEN_W-1:0];
			stat_s1  <= stat_d;
			rd_ok_s1 <= (op_q.kind == OP_READ) && (stat_d == ST_OK);
		end
		if (accept) begin
			op_q <= req;
		end
		if (state_q == S_GATHER && rsp_free) begin
			rsp_q.read_value <= rd_ok_s1 ? gather : '0;
			rsp_q.length     <= len_s1;
			rsp_q.status     <= stat_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) state_q <= S_EXEC;
				end
				S_EXEC: begin
					count_q <= cnt_d[CNT_W-1:0];
					state_q <= S_GATHER;
				end
				S_GATHER: begin
					// hold until the output register frees
					if (rsp_free) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (state_q == S_GATHER && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		IDX_W'(count_q) <= DEPTH_I)
		else $error("list length exceeds capacity");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_EXEC)
		else $error("accepted beat did not start execution");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_EXEC |=> count_q == $past(count_q))
		else $error("length changed outside execution");

	a_gather_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_GATHER && rsp_free) |=> rsp_valid_q && state_q == S_IDLE)
		else $error("gathered result not presented");
`endif

endmodule

// File: design/ilst_cell.sv
// ----------------------------------------------------------------------------
// ilst_cell
// One list slot. Holds a word, takes it from the left or right neighbor when
// the list shifts, loads the incoming word, and taps its word for reads.
// ----------------------------------------------------------------------------
module ilst_cell import ilst_pkg::*; (
	input  logic              clk,
	input  logic [IDX_W-1:0]  idx,
	input  cell_ctrl_t        ctrl,
	input  logic [WORD_W-1:0] left,
	input  logic [WORD_W-1:0] right,
	output logic [WORD_W-1:0] word_q,
	output logic [WORD_W-1:0] tap
);

	logic [WORD_W-1:0] word_d;
	logic [IDX_W:0]    idx_inc;

	assign idx_inc = {1'b0, idx} + (IDX_W+1)'(1);

	always_comb begin
		word_d = word_q;
		if (ctrl.push && idx == ctrl.count) begin
			word_d = ctrl.word;
		end else if (ctrl.insert) begin
			if (idx == ctrl.pos) begin
				word_d = ctrl.word;
			end else if (idx > ctrl.pos && idx <= ctrl.count) begin
				word_d = left;
			end
		end else if (ctrl.erase) begin
			// shift down everything above the erased slot
			if (idx >= ctrl.pos && idx_inc < {1'b0, ctrl.count}) begin
				word_d = right;
			end
		end else if (ctrl.resize && idx >= ctrl.count && idx < ctrl.pos) begin
			word_d = ctrl.word;
		end
	end

	always_ff @(posedge clk) begin
		word_q <= word_d;
	end

	assign tap = (idx == ctrl.pos) ? word_q : '0;

endmodule

// File: bench/list_check_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// list_check_pkg
// Shadow copy of the indexed list and the scoreboard that holds the results
// still owed by the store, checked in order as result beats arrive.
// ----------------------------------------------------------------------------
package list_check_pkg;
	import ilst_pkg::*;

	// the kind code left without an operation
	localparam logic [2:0] OP_UNUSED = 3'd7;

	class list_scoreboard;
		logic signed [WORD_W-1:0] shadow_cells [DEPTH];
		int                       shadow_len;
		rsp_t                     awaited_rsp [$];
		int unsigned              fail_count;

		function new();
			shadow_len = 0;
			fail_count = 0;
		endfunction

		function int fill_level();
			return shadow_len;
		endfunction

		function int pending();
			return awaited_rsp.size();
		endfunction

		// Apply one operation to the shadow list and build its result.
		function rsp_t apply_op(req_t item);
			rsp_t r;
			int   p;
			int   k;
			r = '0;
			r.status = ST_OK;
			p = int'(item.position);
			case (item.kind)
				OP_PUSH: begin
					if (shadow_len >= DEPTH) begin
						r.status = ST_FULL;
					end else begin
						shadow_cells[shadow_len] = item.value;
						shadow_len++;
					end
				end
				OP_POP: begin
					if (shadow_len == 0) r.status = ST_EMPTY;
					else shadow_len--;
				end
				OP_INSERT: begin
					// full wins over a bad position
					if (shadow_len >= DEPTH) begin
						r.status = ST_FULL;
					end else if (p > shadow_len) begin
						r.status = ST_RANGE;
					end else begin
						for (k = shadow_len; k > p; k--) shadow_cells[k] = shadow_cells[k-1];
						shadow_cells[p] = item.value;
						shadow_len++;
					end
				end
				OP_ERASE: begin
					if (shadow_len == 0) begin
						r.status = ST_EMPTY;
					end else if (p >= shadow_len) begin
						r.status = ST_RANGE;
					end else begin
						for (k = p; k + 1 < shadow_len; k++) shadow_cells[k] = shadow_cells[k+1];
						shadow_len--;
					end
				end
				OP_READ: begin
					if (p >= shadow_len) r.status = ST_RANGE;
					else r.read_value = shadow_cells[p];
				end
				OP_CLEAR: begin
					shadow_len = 0;
				end
				OP_RESIZE: begin
					if (p > DEPTH) begin
						r.status = ST_FULL;
					end else begin
						// fill only the new slots, keep the survivors
						for (k = shadow_len; k < p; k++) shadow_cells[k] = item.value;
						shadow_len = p;
					end
				end
				default: ;
			endcase
			r.length = LEN_W'(shadow_len);
			return r;
		endfunction

		function void note_request(req_t item);
			awaited_rsp = {awaited_rsp, apply_op(item)};
		endfunction

		function void report(string field, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
			fail_count++;
			$display("%0t: %s expected %h actual %h", $time, field, want, got);
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			if (awaited_rsp.size() == 0) begin
				fail_count++;
				$display("%0t: result beat with nothing owed, expected none actual %h",
					$time, got);
				return;
			end
			want = awaited_rsp.pop_front();
			if (got.read_value !== want.read_value)
				report("read_value", want.read_value, got.read_value);
			if (got.length !== want.length)
				report("length", WORD_W'(want.length), WORD_W'(got.length));
			if (got.status !== want.status)
				report("status", WORD_W'(want.status), WORD_W'(got.status));
		endfunction
	endclass

endpackage

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the indexed list store with a directed opening and then random
// operations in bursts, stalls the result side on a pattern of its own with
// long hold-offs, and checks every result beat against a shadow list.
// ----------------------------------------------------------------------------
module tb_top;
	import ilst_pkg::*;
	import list_check_pkg::*;

	localparam int RANDOM_ITEMS = 500;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 12;
	localparam int LIMIT_NS     = 6_000_000;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	bit want_hold = 1'b0;

	list_scoreboard sb = new();

	indexed_list_store_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) sb.check_response(rsp);
	end

	// Result side: segments of fixed stall odds, long hold-offs on request.
	initial begin
		int unsigned seg;
		int unsigned pct;
		@(posedge clk);
		forever begin
			if (want_hold) begin
				want_hold = 1'b0;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			seg = $urandom_range(60, 10);
			case ($urandom_range(3))
				0: pct = 0;
				1: pct = 20;
				2: pct = 50;
				default: pct = 85;
			endcase
			repeat (seg) begin
				rsp_stall <= ($urandom_range(99) < pct);
				@(posedge clk);
			end
		end
	end

	initial begin
		#(LIMIT_NS);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic req_t op_beat(logic [2:0] kind, int pos, logic [WORD_W-1:0] val);
		req_t item;
		item.kind     = kind;
		item.position = LEN_W'(pos);
		item.value    = val;
		return item;
	endfunction

	function automatic req_t random_item();
		req_t        item;
		int unsigned len;
		int unsigned w;
		len = sb.fill_level();
		item.value = $urandom;
		if ($urandom_range(99) < 5) begin
			case ($urandom_range(3))
				0: item.value = 32'h7fff_ffff;
				1: item.value = 32'h8000_0000;
				2: item.value = 32'h0000_0000;
				default: item.value = 32'hffff_ffff;
			endcase
		end
		w = $urandom_range(99);
		if (w < 22) item.kind = OP_PUSH;
		else if (w < 34) item.kind = OP_POP;
		else if (w < 54) item.kind = OP_INSERT;
		else if (w < 68) item.kind = OP_ERASE;
		else if (w < 88) item.kind = OP_READ;
		else if (w < 91) item.kind = OP_CLEAR;
		else if (w < 98) item.kind = OP_RESIZE;
		else item.kind = OP_UNUSED;
		item.position = LEN_W'($urandom_range(511));
		// keep most positions legal so the list gets deep
		if ($urandom_range(99) >= 15) begin
			case (item.kind)
				OP_INSERT: item.position = LEN_W'($urandom_range(len));
				OP_ERASE, OP_READ:
					item.position = (len == 0) ? '0 : LEN_W'($urandom_range(len - 1));
				OP_RESIZE: begin
					case ($urandom_range(9))
						0: item.position = LEN_W'(DEPTH);
						1: item.position = LEN_W'(DEPTH + 1);
						2: item.position = '0;
						default: begin
							w = len / 2 + $urandom_range(len / 2 + 12);
							item.position = LEN_W'((w > DEPTH) ? DEPTH : w);
						end
					endcase
				end
				default: ;
			endcase
		end
		return item;
	endfunction

	task automatic offer_item(input req_t item);
		req       <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		sb.note_request(item);
	endtask

	task automatic pause_sender(input int unsigned n);
		req_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	initial begin
		req_t        plan [$];
		int unsigned burst;
		int unsigned gap;
		int unsigned sent;
		int unsigned total;

		plan = {plan, op_beat(OP_POP, 0, 0)};
		plan = {plan, op_beat(OP_ERASE, 0, 0)};
		plan = {plan, op_beat(OP_READ, 0, 0)};
		plan = {plan, op_beat(OP_PUSH, 0, 32'h7fff_ffff)};
		plan = {plan, op_beat(OP_PUSH, 0, 32'h8000_0000)};
		plan = {plan, op_beat(OP_INSERT, 0, 32'hffff_ffff)};
		plan = {plan, op_beat(OP_INSERT, 3, 32'h0000_0000)};
		plan = {plan, op_beat(OP_INSERT, 5, 32'h0000_0001)};
		plan = {plan, op_beat(OP_READ, 3, 0)};
		plan = {plan, op_beat(OP_READ, 4, 0)};
		plan = {plan, op_beat(OP_ERASE, 4, 0)};
		plan = {plan, op_beat(OP_ERASE, 1, 0)};
		plan = {plan, op_beat(OP_RESIZE, 10, 32'h5555_5555)};
		plan = {plan, op_beat(OP_READ, 9, 0)};
		plan = {plan, op_beat(OP_RESIZE, 2, 32'h1234_5678)};
		plan = {plan, op_beat(OP_READ, 1, 0)};
		plan = {plan, op_beat(OP_RESIZE, DEPTH, 32'haaaa_aaaa)};
		plan = {plan, op_beat(OP_PUSH, 0, 32'h0bad_f00d)};
		plan = {plan, op_beat(OP_INSERT, 300, 32'h0bad_f00d)};
		plan = {plan, op_beat(OP_READ, DEPTH - 1, 0)};
		plan = {plan, op_beat(OP_ERASE, 0, 0)};
		plan = {plan, op_beat(OP_RESIZE, DEPTH + 1, 0)};
		plan = {plan, op_beat(OP_UNUSED, 511, 32'hffff_ffff)};
		plan = {plan, op_beat(OP_RESIZE, 0, 32'hdead_beef)};
		plan = {plan, op_beat(OP_PUSH, 0, 32'h0000_0005)};
		plan = {plan, op_beat(OP_CLEAR, 0, 0)};

		total = plan.size() + RANDOM_ITEMS;
		sent  = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		while (sent < total) begin
			burst = ($urandom_range(3) == 0) ? $urandom_range(40, 15) : $urandom_range(12, 1);
			repeat (burst) begin
				if (sent < total) begin
					// hold the result side off so the store backs up
					if (sent == plan.size() || sent == plan.size() + RANDOM_ITEMS / 2)
						want_hold = 1'b1;
					offer_item((sent < plan.size()) ? plan[sent] : random_item());
					sent++;
				end
			end
			gap = ($urandom_range(9) < 3) ? 0 : $urandom_range(6, 1);
			if (gap != 0) pause_sender(gap);
		end
		req_valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.fail_count == 0 && sb.pending() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// File: sim.f
design/ilst_pkg.sv
design/ilst_cell.sv
design/indexed_list_store_unit.sv
bench/list_check_pkg.sv
bench/tb_top.sv
